// File: rtl/encoder_speed_p_controller_assert.svh
// assertion macros used by the encoder speed controller checker
`ifndef ENCODER_SPEED_P_CONTROLLER_ASSERT_SVH
`define ENCODER_SPEED_P_CONTROLLER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define ESP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent checked in the cycle after the antecedent
`define ESP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: rtl/esp_pkg.sv
// shared types and constants of the encoder speed controller
`timescale 1ns / 1ps
`default_nettype none

package esp_pkg;

	// beat widths
	localparam int IN_W  = 64;
	localparam int OUT_W = 40;

	// configuration port
	localparam int IDX_W = 2;
	localparam int CFG_W = 18;

	typedef enum logic [IDX_W-1:0] {
		REG_TARGET_SPEED = 2'd0,
		REG_LOOP_GAIN    = 2'd1,
		REG_DEADBAND     = 2'd2,
		REG_SPEED_SCALE  = 2'd3
	} reg_idx_t;

	localparam logic signed [17:0] TARGET_RST   = 18'sd0;
	localparam logic [6:0]         GAIN_RST     = 7'd7;
	localparam logic [13:0]        DEADBAND_RST = 14'd5;
	localparam logic [15:0]        SCALE_RST    = 16'd9016;

	// arithmetic widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DIVR_W  = 32;
	localparam int DIFF_W  = 25;
	localparam int SUM_W   = 26;

	// divide by 100 as a reciprocal multiply, exact for any 32-bit product
	localparam int               CPROD_W    = 32;
	localparam int               RCP_W      = 31;
	localparam logic [RCP_W-1:0] GAIN_RECIP = 31'h51EB851F;
	localparam int               GAIN_SHIFT = 37;

	localparam logic [23:0]       SPEED_LIM    = 24'h800000;
	localparam logic [23:0]       SPEED_MAX    = 24'h7FFFFF;
	localparam logic signed [7:0] CMD_MAX      = 8'sh7F;
	localparam logic signed [7:0] CMD_MIN      = -8'sd128;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic div_start;
		logic sel_ctl;
		logic spd_fin;
		logic ctl_diff;
		logic ctl_mul;
		logic ctl_quo;
		logic ctl_fin;
		logic out_load;
	} esp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_dt;
		logic apply;
		logic div_busy;
		logic out_free;
	} esp_sts_t;

endpackage

`default_nettype wire

// File: rtl/esp_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module esp_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [esp_pkg::PROD_W-1:0]  dividend,
	input  wire logic [esp_pkg::DIVR_W-1:0]  divisor,
	output logic                             busy,
	output logic [esp_pkg::PROD_W-1:0]       quotient
);

	localparam int PW    = esp_pkg::PROD_W;
	localparam int DW    = esp_pkg::DIVR_W;
	localparam int CNT_W = $clog2(PW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [DW:0]      shifted;
	logic [DW+1:0]    trial;

	assign shifted  = {rem_q, quo_q[PW-1]};
	assign trial    = {1'b0, shifted} - {2'b00, dvs_q};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(PW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b0};
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/esp_dp.sv
// datapath: registers, shared multiplier, divider and output register
`timescale 1ns / 1ps
`default_nettype none

module esp_dp #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire esp_pkg::esp_cmd_t            cmd,
	output esp_pkg::esp_sts_t                 sts,
	input  wire logic                         cfg_wen,
	input  wire logic [esp_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [esp_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [esp_pkg::IN_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [esp_pkg::OUT_W-1:0]         m_tdata
);

	localparam int CW  = COUNT_WIDTH;
	localparam int PW  = esp_pkg::PROD_W;
	localparam int DFW = esp_pkg::DIFF_W;
	localparam int SW  = esp_pkg::SUM_W;
	localparam int RW  = esp_pkg::CPROD_W + esp_pkg::RCP_W;

	// configuration
	logic signed [17:0] target_q;
	logic [6:0]         gain_q;
	logic [13:0]        deadband_q;
	logic [15:0]        scale_q;

	// state carried between items
	logic [CW-1:0]      last_count_q;
	logic [31:0]        last_time_q;
	logic signed [23:0] speed_q;
	logic signed [7:0]  drive_q;

	// per-item working registers
	logic [CW-1:0]      mag_q;
	logic               neg_q;
	logic [31:0]        dt_q;
	logic               zero_dt_q;
	logic               changed_q;
	logic [DFW-1:0]     adiff_q;
	logic               dneg_q;
	logic               apply_q;
	logic [esp_pkg::CPROD_W-1:0] cprod_q;
	logic [SW-2:0]      cquo_q;

	logic                   m_tvalid_q;
	logic [esp_pkg::OUT_W-1:0] m_tdata_q;

	logic [CW-1:0]      cnt_in;
	logic [31:0]        ts_in;
	logic [CW-1:0]      delta;
	logic [31:0]        dt_in;

	logic [esp_pkg::MUL_A_W-1:0] mul_a;
	logic [esp_pkg::MUL_B_W-1:0] mul_b;
	logic [PW-1:0]               product;
	logic [PW-1:0]               quo;
	logic                        div_busy;
	logic [RW-1:0]               rcp_prod;

	logic [23:0]           q_lim;
	logic signed [23:0]    speed_new;
	logic signed [DFW-1:0] diff;
	logic [DFW-1:0]        adiff;
	logic signed [SW-1:0]  step_mag;
	logic signed [SW-1:0]  sum;
	logic signed [7:0]     drive_new;

	assign cnt_in = s_tdata[CW-1:0];
	assign ts_in  = s_tdata[63:32];
	assign delta  = cnt_in - last_count_q;
	assign dt_in  = ts_in - last_time_q;

	// one multiplier shared by the speed and the control step
	assign mul_a   = cmd.sel_ctl ? esp_pkg::MUL_A_W'(adiff_q) : esp_pkg::MUL_A_W'(mag_q);
	assign mul_b   = cmd.sel_ctl ? esp_pkg::MUL_B_W'(gain_q) : scale_q;
	assign product = PW'(mul_a) * PW'(mul_b);

	// speed divide by the sample interval
	esp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (product),
		.divisor  (dt_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	// gain product over 100 from the registered product
	assign rcp_prod = RW'(cprod_q) * RW'(esp_pkg::GAIN_RECIP);

	// speed saturation on the magnitude, then sign
	always_comb begin
		q_lim = (quo > PW'(esp_pkg::SPEED_LIM)) ? esp_pkg::SPEED_LIM : quo[23:0];
		if (neg_q) begin
			speed_new = $signed(-q_lim);
		end else if (q_lim == esp_pkg::SPEED_LIM) begin
			speed_new = $signed(esp_pkg::SPEED_MAX);
		end else begin
			speed_new = $signed(q_lim);
		end
	end

	assign diff  = DFW'(target_q) - DFW'(speed_q);
	assign adiff = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);

	// command update with clamp
	always_comb begin
		step_mag = $signed(SW'(cquo_q));
		sum      = SW'(drive_q) + (dneg_q ? -step_mag : step_mag);
		if (sum > SW'(esp_pkg::CMD_MAX)) begin
			drive_new = esp_pkg::CMD_MAX;
		end else if (sum < SW'(esp_pkg::CMD_MIN)) begin
			drive_new = esp_pkg::CMD_MIN;
		end else begin
			drive_new = sum[7:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= esp_pkg::TARGET_RST;
			gain_q     <= esp_pkg::GAIN_RST;
			deadband_q <= esp_pkg::DEADBAND_RST;
			scale_q    <= esp_pkg::SCALE_RST;
		end else if (cfg_wen) begin
			case (esp_pkg::reg_idx_t'(cfg_index))
				esp_pkg::REG_TARGET_SPEED: target_q   <= $signed(cfg_data[17:0]);
				esp_pkg::REG_LOOP_GAIN:    gain_q     <= cfg_data[6:0];
				esp_pkg::REG_DEADBAND:     deadband_q <= cfg_data[13:0];
				esp_pkg::REG_SPEED_SCALE:  scale_q    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// state kept from item to item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
			last_time_q  <= '0;
			speed_q      <= '0;
			drive_q      <= '0;
		end else begin
			if (cmd.load_in) begin
				last_count_q <= cnt_in;
				last_time_q  <= ts_in;
			end
			if (cmd.spd_fin) begin
				speed_q <= speed_new;
			end
			if (cmd.ctl_diff && (target_q == '0)) begin
				drive_q <= '0;
			end else if (cmd.ctl_fin) begin
				drive_q <= drive_new;
			end
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_q     <= delta[CW-1] ? -delta : delta;
			neg_q     <= delta[CW-1];
			dt_q      <= dt_in;
			zero_dt_q <= (dt_in == '0);
			changed_q <= 1'b0;
		end
		if (cmd.ctl_diff) begin
			adiff_q <= adiff;
			dneg_q  <= diff[DFW-1];
			apply_q <= (adiff >= DFW'(deadband_q));
			if (target_q == '0) begin
				changed_q <= 1'b1;
			end
		end
		if (cmd.ctl_mul) begin
			cprod_q <= product[esp_pkg::CPROD_W-1:0];
		end
		if (cmd.ctl_quo) begin
			cquo_q <= rcp_prod[esp_pkg::GAIN_SHIFT+SW-2:esp_pkg::GAIN_SHIFT];
		end
		if (cmd.ctl_fin) begin
			changed_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {6'b000000, zero_dt_q, changed_q, speed_q, drive_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.zero_dt  = zero_dt_q;
	assign sts.apply    = apply_q;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

// File: rtl/esp_ctrl.sv
// controller state machine sequencing one sample through the datapath
`timescale 1ns / 1ps
`default_nettype none

module esp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire esp_pkg::esp_sts_t sts,
	output esp_pkg::esp_cmd_t      cmd
);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_MUL_SPD = 9'b000000010,
		S_DIV_SPD = 9'b000000100,
		S_SPD_FIN = 9'b000001000,
		S_CTL_DIF = 9'b000010000,
		S_MUL_CTL = 9'b000100000,
		S_RCP_CTL = 9'b001000000,
		S_CTL_FIN = 9'b010000000,
		S_OUT     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL_SPD;
				end
			end
			S_MUL_SPD: begin
				cmd.div_start = !sts.zero_dt;
				state_d       = sts.zero_dt ? S_CTL_DIF : S_DIV_SPD;
			end
			S_DIV_SPD: begin
				if (!sts.div_busy) begin
					state_d = S_SPD_FIN;
				end
			end
			S_SPD_FIN: begin
				cmd.spd_fin = 1'b1;
				state_d     = S_CTL_DIF;
			end
			S_CTL_DIF: begin
				cmd.ctl_diff = 1'b1;
				state_d      = S_MUL_CTL;
			end
			S_MUL_CTL: begin
				cmd.sel_ctl = 1'b1;
				cmd.ctl_mul = sts.apply;
				state_d     = sts.apply ? S_RCP_CTL : S_OUT;
			end
			S_RCP_CTL: begin
				cmd.ctl_quo = 1'b1;
				state_d     = S_CTL_FIN;
			end
			S_CTL_FIN: begin
				cmd.ctl_fin = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/encoder_speed_p_controller.sv
// top level: encoder speed measurement and proportional speed loop
// sequence: idle takes the beat, then speed multiply, speed divide, speed finish, error,
//   gain multiply, reciprocal scale, command finish and output states; a zero interval skips
//   the divide and an error inside the deadband skips the scale and the command finish
// one sample at a time; a result waiting in the output register does not block the next beat
// reset: arst_n clears the sample history, speed and command and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module encoder_speed_p_controller #(
	parameter int COUNT_WIDTH = 32 // encoder bits that take part in the delta, 16 to 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write port
	input  wire logic                      cfg_wen,
	input  wire logic [esp_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [esp_pkg::CFG_W-1:0] cfg_data,
	// sample stream
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [esp_pkg::IN_W-1:0]  s_tdata,  // encoder_count[31:0], timestamp[63:32]
	// result stream
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [esp_pkg::OUT_W-1:0]      m_tdata   // motor_command[7:0], measured_speed[31:8],
	                                                 // command_changed[32], zero_interval[33]
);

	// command and status between the sequencer and the datapath
	esp_pkg::esp_cmd_t cmd;
	esp_pkg::esp_sts_t sts;

	// sequencer: accept, speed multiply and divide, error, gain multiply and scale, emit
	esp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: wrap-aware count delta, one shared multiplier, speed divider,
	// reciprocal multiply for the gain over 100, speed saturation, deadband test
	// and command clamp
	esp_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

// File: rtl/esp_checker.sv
// port-level checker for the encoder speed controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_speed_p_controller_assert.svh"

module esp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [esp_pkg::OUT_W-1:0] m_tdata
);

	// a stalled result beat stays put
	`ESP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// one sample in flight: ready drops right after an accepted beat
	`ESP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second sample taken while busy")

	// no result can appear in the cycle after a sample is taken
	`ESP_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")

	// a new result only comes out of a busy block
	`ESP_ASSERT_SAME(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result without a sample in work")

endmodule

bind encoder_speed_p_controller esp_checker u_esp_checker (.*);

`default_nettype wire

// File: verif/tb_encoder_speed_p_controller.sv
// self-checking testbench for the encoder speed measurement and proportional speed loop
`timescale 1ns / 1ps

module tb_encoder_speed_p_controller;

	// run limits
	localparam int STALL_LIMIT = 5000; // cycles with no beat on either side
	localparam int HOLD_CYCLES = 600;  // long receiver hold-off for the fill-up test
	localparam int IDLE_GAP    = 8;    // quiet cycles before a register write
	localparam int TAIL_CYCLES = 120;  // covers the worst result latency

	// predictor arithmetic limits
	localparam longint unsigned SPEED_CAP = 64'd8388608;
	localparam longint SPEED_TOP = 64'sd8388607;
	localparam longint DRIVE_TOP = 64'sd127;
	localparam longint DRIVE_BOT = -64'sd128;
	localparam longint GAIN_DIV  = 64'sd100;

	// one result beat, msb first so that it overlays m_tdata[33:0]
	typedef struct packed {
		logic              zero_interval;
		logic              command_changed;
		logic signed [23:0] measured_speed;
		logic signed [7:0]  motor_command;
	} drive_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wen = 1'b0;
	logic [esp_pkg::IDX_W-1:0]     cfg_index = '0;
	logic [esp_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [esp_pkg::IN_W-1:0]      s_tdata = '0;  // encoder_count[31:0], timestamp[63:32]
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [esp_pkg::OUT_W-1:0]     m_tdata;       // motor_command[7:0], measured_speed[31:8],
	                                              // command_changed[32], zero_interval[33]

	// predictor copy of the registers and the loop state
	logic signed [17:0]   target_reg = esp_pkg::TARGET_RST;
	logic [6:0]           gain_reg = esp_pkg::GAIN_RST;
	logic [13:0]          deadband_reg = esp_pkg::DEADBAND_RST;
	logic [15:0]          scale_reg = esp_pkg::SCALE_RST;
	logic [31:0]          pos_last = '0;
	logic [31:0]          time_last = '0;
	logic signed [23:0]   speed_now = '0;
	logic signed [7:0]    drive_now = '0;

	// results still owed by the block, oldest first
	drive_result_t        drive_due[$];

	// idling control
	logic                 calm = 1'b0;   // no idling on either side while set
	int                   hold_seq = 0;  // bumped to ask the receiver for a long hold-off
	int                   hold_seen = 0;
	int                   hold_left = 0;

	// bookkeeping
	int                   mismatch_count = 0;
	int                   samples_sent = 0;
	int                   results_checked = 0;
	int                   zero_hits = 0;
	int                   changed_hits = 0;
	int                   rail_hits = 0;
	int                   settings_used = 0;
	int                   stall_cycles = 0;

	encoder_speed_p_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// speed update then proportional command update for one accepted sample
	function automatic drive_result_t next_drive_result(input logic [31:0] cnt,
			input logic [31:0] ts);
		drive_result_t     r;
		logic [31:0]       span;
		logic [31:0]       ticks;
		longint unsigned   mag;
		longint unsigned   quot;
		longint            spd;
		longint            tgt;
		longint            diff;
		longint            adiff;
		longint            cmd;
		longint            dband;
		longint            gain;
		span = cnt - pos_last;
		ticks = ts - time_last;
		r.zero_interval = (ticks == 32'd0);
		r.command_changed = 1'b0;
		if (ticks != 32'd0) begin
			// shorter way round the counter, exact half range counts as backward
			mag = 64'(span);
			if (span[31])
				mag = 64'h1_0000_0000 - mag;
			quot = (mag * 64'(scale_reg)) / 64'(ticks);
			if (quot > SPEED_CAP)
				quot = SPEED_CAP;
			spd = longint'(quot);
			if (span[31])
				spd = -spd;
			if (spd > SPEED_TOP)
				spd = SPEED_TOP;
			speed_now = spd[23:0];
		end
		pos_last = cnt;
		time_last = ts;

		cmd = longint'(drive_now);
		tgt = longint'(target_reg);
		dband = longint'(deadband_reg);
		gain = longint'(gain_reg);
		// zero target parks the motor before the error term is applied
		if (tgt == 0) begin
			cmd = 0;
			r.command_changed = 1'b1;
		end
		spd = longint'(speed_now);
		diff = tgt - spd;
		adiff = (diff < 0) ? -diff : diff;
		if (adiff >= dband) begin
			cmd = cmd + (gain * diff) / GAIN_DIV;
			if (cmd > DRIVE_TOP)
				cmd = DRIVE_TOP;
			if (cmd < DRIVE_BOT)
				cmd = DRIVE_BOT;
			r.command_changed = 1'b1;
		end
		drive_now = cmd[7:0];
		r.motor_command = drive_now;
		r.measured_speed = speed_now;
		return r;
	endfunction

	task automatic log_mismatch(input string what, input longint seen, input longint due);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, seen, due);
	endtask

	// offer one sample beat, with a random gap in front unless calm
	task automatic send_sample(input logic [31:0] cnt, input logic [31:0] ts);
		if (!calm && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 110)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ts, cnt};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		drive_due.push_back(next_drive_result(cnt, ts));
		samples_sent++;
	endtask

	// stop offering and wait for every owed result
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	// write all four registers back to back while the block is idle
	task automatic load_settings(input int tgt, input int gain, input int dband,
			input int scale);
		settle_idle();
		cfg_wen <= 1'b1;
		cfg_index <= esp_pkg::REG_TARGET_SPEED;
		cfg_data <= tgt[17:0];
		@(posedge clk);
		cfg_index <= esp_pkg::REG_LOOP_GAIN;
		cfg_data <= gain[17:0];
		@(posedge clk);
		cfg_index <= esp_pkg::REG_DEADBAND;
		cfg_data <= dband[17:0];
		@(posedge clk);
		cfg_index <= esp_pkg::REG_SPEED_SCALE;
		cfg_data <= scale[17:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		target_reg = tgt[17:0];
		gain_reg = gain[6:0];
		deadband_reg = dband[13:0];
		scale_reg = scale[15:0];
		settings_used++;
	endtask

	// mostly plausible motion around the target, some zero intervals, some raw noise
	task automatic send_random(input int n);
		int      pick;
		int      dt;
		longint  spread;
		longint  want;
		longint  sc;
		longint  dcount;
		for (int i = 0; i < n; i++) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 20) begin
				send_sample($urandom, $urandom);
			end else if (pick < 30) begin
				send_sample(pos_last + 32'($urandom_range(0, 4000)) - 32'd2000, time_last);
			end else begin
				dt = int'($urandom_range(1, 3000));
				spread = longint'(deadband_reg) + 3000;
				want = longint'(target_reg)
					+ longint'($urandom_range(0, 32'(2 * spread))) - spread;
				sc = longint'(scale_reg);
				if (sc == 0)
					dcount = longint'($urandom_range(0, 2000)) - 1000;
				else
					dcount = (want * longint'(dt)) / sc;
				send_sample(pos_last + dcount[31:0], time_last + 32'(dt));
			end
		end
	endtask

	// reset defaults: target zero forces the command, first sample has no interval
	task automatic test_reset_defaults();
		send_sample(32'd0, 32'd0);
		send_sample(32'd100, 32'd10);
		send_sample(32'd100, 32'd10);
	endtask

	// field extremes, timestamp wrap, speed overflow and command top rail
	task automatic test_field_extremes();
		load_settings(100000, 127, 0, 65535);
		send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_sample(32'h8000_0000, 32'h0000_0000);
		send_sample(32'hFFFF_FFFF, 32'h0000_0001);
		send_sample(32'h0000_0000, 32'h8000_0000);
	endtask

	// jump of exactly half the counter range reads as backward, one less as forward
	task automatic test_half_range();
		send_sample(pos_last + 32'h8000_0000, time_last + 32'd1);
		send_sample(pos_last + 32'h7FFF_FFFF, time_last + 32'd1);
	endtask

	// negative target against a saturated forward speed drives the bottom rail
	task automatic test_command_floor();
		load_settings(-100000, 127, 0, 65535);
		send_sample(pos_last + 32'd1000, time_last + 32'd1);
		send_sample(pos_last + 32'd1000, time_last + 32'd1);
	endtask

	// repeated timestamp holds the speed, zero deadband still rewrites the command
	task automatic test_zero_interval();
		load_settings(3000, 20, 0, 9016);
		send_sample(pos_last + 32'd77, time_last);
		send_sample(pos_last + 32'd77, time_last);
	endtask

	// error exactly at the deadband acts, one inside does not
	task automatic test_deadband_edge();
		load_settings(1000, 10, 50, 1);
		send_sample(pos_last + 32'd950, time_last + 32'd1);
		send_sample(pos_last + 32'd951, time_last + 32'd1);
		send_sample(pos_last + 32'd1050, time_last + 32'd1);
	endtask

	// zero scale gives zero speed in both directions
	task automatic test_zero_scale();
		load_settings(0, 7, 5, 0);
		send_sample(pos_last + 32'd500, time_last + 32'd3);
		send_sample(pos_last - 32'd500, time_last + 32'd3);
	endtask

	// random samples under several settings, one phase with no idling
	task automatic test_random_control();
		load_settings(20000, 7, 5, 9016);
		send_random(220);
		load_settings(-100000, 127, 0, 65535);
		send_random(210);
		load_settings(100000, 0, 10000, 1);
		calm <= 1'b1;
		send_random(210);
		calm <= 1'b0;
		load_settings(0, 50, 100, 9016);
		send_random(210);
		load_settings(55555, 1, 0, 30000);
		send_random(210);
	endtask

	// receiver holds off long enough for the block to fill and stall its input
	task automatic test_output_stall();
		load_settings(-20000, 64, 200, 9016);
		hold_seq <= hold_seq + 1;
		send_random(14);
	endtask

	// receiver: random ready, steady when calm, long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= 14);
		end
	end

	// compare every result beat with the oldest owed result
	always @(posedge clk) begin : result_check
		drive_result_t got;
		drive_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[33:0];
			if (drive_due.size() == 0) begin
				log_mismatch("result beat with nothing owed", longint'(got), 0);
			end else begin
				want = drive_due.pop_front();
				results_checked++;
				if (want.zero_interval)
					zero_hits++;
				if (want.command_changed)
					changed_hits++;
				if (want.motor_command == esp_pkg::CMD_MAX
						|| want.motor_command == esp_pkg::CMD_MIN)
					rail_hits++;
				if (got.motor_command !== want.motor_command)
					log_mismatch("motor_command", longint'(got.motor_command),
						longint'(want.motor_command));
				if (got.measured_speed !== want.measured_speed)
					log_mismatch("measured_speed", longint'(got.measured_speed),
						longint'(want.measured_speed));
				if (got.command_changed !== want.command_changed)
					log_mismatch("command_changed", longint'(got.command_changed),
						longint'(want.command_changed));
				if (got.zero_interval !== want.zero_interval)
					log_mismatch("zero_interval", longint'(got.zero_interval),
						longint'(want.zero_interval));
				if (m_tdata[esp_pkg::OUT_W-1:34] !== '0)
					log_mismatch("result padding", longint'(m_tdata[esp_pkg::OUT_W-1:34]), 0);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results owed", STALL_LIMIT,
				drive_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_half_range();
		test_command_floor();
		test_zero_interval();
		test_deadband_edge();
		test_zero_scale();
		test_random_control();
		test_output_stall();

		// drain, then give a stray extra beat time to show up
		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d samples under %0d register settings, %0d results compared",
			samples_sent, settings_used + 1, results_checked);
		$display("  %0d held on a zero interval, %0d command rewrites, %0d at a command rail",
			zero_hits, changed_hits, rail_hits);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: encoder_speed_p_controller.f
+incdir+rtl
rtl/esp_pkg.sv
rtl/esp_div.sv
rtl/esp_dp.sv
rtl/esp_ctrl.sv
rtl/encoder_speed_p_controller.sv
rtl/esp_checker.sv
verif/tb_encoder_speed_p_controller.sv
